// ===== hdl/assert_macros.svh =====
// assert_macros.svh: shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/anxb_pkg.sv =====
// ============================================================================
// anxb_pkg
// Types and constants shared by the Annex-B NAL splitter.
// ============================================================================
package anxb_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int OUT_LEN_BITS = 32;

    localparam logic [1:0] K_PAYLOAD = 2'd0;
    localparam logic [1:0] K_CLOSE   = 2'd1;
    localparam logic [1:0] K_SUMMARY = 2'd2;

    localparam logic [4:0] T_IDR = 5'd5;
    localparam logic [4:0] T_SPS = 5'd7;
    localparam logic [4:0] T_PPS = 5'd8;
    localparam logic [4:0] T_AUD = 5'd9;

    localparam logic [7:0] B_ZERO = 8'h00;
    localparam logic [7:0] B_ONE  = 8'h01;

    // frame flag bits
    localparam int F_IDR = 0;
    localparam int F_SPS = 1;
    localparam int F_PPS = 2;
    localparam int F_SMP = 3;
    localparam int F_OVF = 4;

    typedef enum logic [3:0] {
        PH_MAIN = 4'b0001,
        PH_RELB = 4'b0010,
        PH_FREL = 4'b0100,
        PH_SUM  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]             held;
        logic                   in_unit;
        logic [LENGTH_BITS-1:0] len;
        logic                   ovf;
        logic [4:0]             ctype;
        logic [4:0]             flags;
    } t_state;

    typedef struct packed {
        logic [1:0]              kind;
        logic [7:0]              pbyte;
        logic [4:0]              utype;
        logic                    first;
        logic [OUT_LEN_BITS-1:0] length;
        logic                    sample;
        logic                    idr;
        logic                    sps;
        logic                    pps;
        logic                    avcc_ok;
        logic                    last;
    } t_rec;

    typedef struct packed {
        t_state st;
        t_rec   rec;
        logic   vld;
    } t_op;

endpackage

// ===== hdl/annexb_nal_splitter_top.sv =====
// ============================================================================
// annexb_nal_splitter_top
// Annex-B byte stream to NAL payload, end-of-NAL and frame summary records.
// ============================================================================
// Input channel: one stream byte per item plus frame_end on the last byte of
// an access unit. Output channel: one record per item, rec_kind selects
// payload byte, end of NAL or frame summary; last_of_run marks the final
// record caused by an input byte.
// Each input byte is held in an input register and worked off by a step unit
// that emits at most one record per cycle into the result register while the
// receiver does not stall. A byte that yields zero or one record is done in a
// single step, so plain payload streams at one byte per clock when unstalled.
// A byte that flushes held zeros takes an extra step per released zero; a
// frame_end byte adds up to three zero releases, one close step and one
// summary step. The first record passes the input and result registers.
// Reset clears all parser state and the result register's valid flag;
// parsing restarts before the first start code. When the receiver stalls,
// the result holds and the step unit waits, so the input stalls once the
// current byte is not finished.
// ============================================================================
module annexb_nal_splitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_rec_kind,
    output logic [7:0]  o_payload_byte,
    output logic [4:0]  o_unit_type,
    output logic        o_first_of_unit,
    output logic [31:0] o_unit_length,
    output logic        o_is_sample_unit,
    output logic        o_frame_has_idr,
    output logic        o_frame_has_sps,
    output logic        o_frame_has_pps,
    output logic        o_frame_avcc_ok,
    output logic        o_last_of_run
);
    import anxb_pkg::*;

    logic       r_busy;
    t_phase     r_phase;
    t_state     r_st;
    logic [7:0] r_byte;
    logic       r_fe;

    t_state n_st;
    t_phase n_phase;
    t_rec   s_rec;
    logic   s_rec_vld;
    logic   s_done;
    logic   out_free;
    logic   step_en;
    logic   in_acc;
    t_rec   out_rec;

    anxb_step u_step (
        .i_st      (r_st),
        .i_phase   (r_phase),
        .i_byte    (r_byte),
        .i_fe      (r_fe),
        .o_st      (n_st),
        .o_phase   (n_phase),
        .o_rec     (s_rec),
        .o_rec_vld (s_rec_vld),
        .o_done    (s_done)
    );

    anxb_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step_en && s_rec_vld),
        .i_rec   (s_rec),
        .i_ready (i_out_ready),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_rec   (out_rec)
    );

    assign step_en    = r_busy && out_free;
    assign o_in_ready = !r_busy || (step_en && s_done);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_MAIN;
            r_st    <= '0;
        end else begin
            if (step_en) begin
                r_st <= n_st;
            end
            if (in_acc) begin
                r_busy  <= 1'b1;
                r_phase <= PH_MAIN;
            end else begin
                if (step_en) begin
                    r_phase <= n_phase;
                end
                if (step_en && s_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in_byte;
            r_fe   <= i_frame_end;
        end
    end

    assign o_rec_kind       = out_rec.kind;
    assign o_payload_byte   = out_rec.pbyte;
    assign o_unit_type      = out_rec.utype;
    assign o_first_of_unit  = out_rec.first;
    assign o_unit_length    = out_rec.length;
    assign o_is_sample_unit = out_rec.sample;
    assign o_frame_has_idr  = out_rec.idr;
    assign o_frame_has_sps  = out_rec.sps;
    assign o_frame_has_pps  = out_rec.pps;
    assign o_frame_avcc_ok  = out_rec.avcc_ok;
    assign o_last_of_run    = out_rec.last;

endmodule

// ===== hdl/anxb_step.sv =====
// ============================================================================
// anxb_step
// One micro-step of the parser: state, held item and phase in; at most one
// record, next state and next phase out.
// ============================================================================
module anxb_step (
    input  anxb_pkg::t_state i_st,
    input  anxb_pkg::t_phase i_phase,
    input  logic [7:0]       i_byte,
    input  logic             i_fe,
    output anxb_pkg::t_state o_st,
    output anxb_pkg::t_phase o_phase,
    output anxb_pkg::t_rec   o_rec,
    output logic             o_rec_vld,
    output logic             o_done
);
    import anxb_pkg::*;

    function automatic t_op put_payload(t_state s, logic [7:0] b);
        t_op  r;
        logic first;
        r       = '0;
        r.st    = s;
        r.vld   = s.in_unit;
        first   = (s.len == '0) && !s.ovf;
        if (s.in_unit) begin
            if (first) begin
                r.st.ctype = b[4:0];
            end
            r.rec.kind  = K_PAYLOAD;
            r.rec.pbyte = b;
            r.rec.utype = first ? b[4:0] : s.ctype;
            r.rec.first = first;
            if (s.len == '1) begin
                r.st.ovf = 1'b1;
            end else begin
                r.st.len = s.len + LENGTH_BITS'(1);
            end
        end
        return r;
    endfunction

    function automatic t_op close_unit(t_state s);
        t_op  r;
        logic smp;
        r   = '0;
        r.st = s;
        smp = !(s.ctype == T_SPS || s.ctype == T_PPS || s.ctype == T_AUD);
        r.vld = s.in_unit && ((s.len != '0) || s.ovf);
        if (r.vld) begin
            r.rec.kind   = K_CLOSE;
            r.rec.utype  = s.ctype;
            r.rec.length = OUT_LEN_BITS'(s.len);
            r.rec.sample = smp;
            if (s.ctype == T_IDR) r.st.flags[F_IDR] = 1'b1;
            if (s.ctype == T_SPS) r.st.flags[F_SPS] = 1'b1;
            if (s.ctype == T_PPS) r.st.flags[F_PPS] = 1'b1;
            if (smp) begin
                r.st.flags[F_SMP] = 1'b1;
                if (s.ovf) r.st.flags[F_OVF] = 1'b1;
            end
        end
        r.st.len   = '0;
        r.st.ovf   = 1'b0;
        r.st.ctype = '0;
        return r;
    endfunction

    t_op  op;
    logic main_done;

    always_comb begin
        op        = '0;
        op.st     = i_st;
        o_phase   = i_phase;
        main_done = 1'b0;
        o_done    = 1'b0;
        case (i_phase)
            PH_MAIN: begin
                if (i_byte == B_ZERO) begin
                    if (i_st.held != 2'd3) begin
                        op.st.held = i_st.held + 2'd1;
                    end else begin
                        op = put_payload(i_st, B_ZERO);
                    end
                    main_done = 1'b1;
                end else if (i_byte == B_ONE && i_st.held[1]) begin
                    op            = close_unit(i_st);
                    op.st.in_unit = 1'b1;
                    op.st.held    = 2'd0;
                    main_done     = 1'b1;
                end else if (i_st.held != 2'd0) begin
                    op         = put_payload(i_st, B_ZERO);
                    op.st.held = i_st.held - 2'd1;
                    o_phase    = PH_RELB;
                end else begin
                    op        = put_payload(i_st, i_byte);
                    main_done = 1'b1;
                end
            end
            PH_RELB: begin
                if (i_st.held != 2'd0) begin
                    op         = put_payload(i_st, B_ZERO);
                    op.st.held = i_st.held - 2'd1;
                end else begin
                    op        = put_payload(i_st, i_byte);
                    main_done = 1'b1;
                end
            end
            PH_FREL: begin
                if (i_st.held != 2'd0) begin
                    op         = put_payload(i_st, B_ZERO);
                    op.st.held = i_st.held - 2'd1;
                end else begin
                    op      = close_unit(i_st);
                    o_phase = PH_SUM;
                end
            end
            PH_SUM: begin
                op.vld          = 1'b1;
                op.rec.kind     = K_SUMMARY;
                op.rec.idr      = i_st.flags[F_IDR];
                op.rec.sps      = i_st.flags[F_SPS];
                op.rec.pps      = i_st.flags[F_PPS];
                op.rec.avcc_ok  = i_st.flags[F_SMP] && !i_st.flags[F_OVF];
                op.st           = '0;
                o_done          = 1'b1;
            end
            default: begin
                o_done = 1'b1;
            end
        endcase
        if (main_done) begin
            if (i_fe) begin
                o_phase = PH_FREL;
            end else begin
                o_done = 1'b1;
            end
        end
        o_st          = op.st;
        o_rec         = op.rec;
        o_rec.last    = o_done;
        o_rec_vld     = op.vld;
    end

endmodule

// ===== hdl/anxb_out_reg.sv =====
// ============================================================================
// anxb_out_reg
// Result register with valid/ready toward the receiver.
// ============================================================================
module anxb_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  anxb_pkg::t_rec i_rec,
    input  logic           i_ready,
    output logic           o_free,
    output logic           o_valid,
    output anxb_pkg::t_rec o_rec
);
    import anxb_pkg::*;

    logic r_valid;
    t_rec r_rec;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_rec <= i_rec;
        end
    end

endmodule

// ===== hdl/anxb_checker.sv =====
// ============================================================================
// anxb_checker
// Port-level checks on the splitter's output records.
// ============================================================================
`include "assert_macros.svh"

module anxb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_rec_kind,
    input logic [7:0]  o_payload_byte,
    input logic        o_first_of_unit,
    input logic [31:0] o_unit_length,
    input logic        o_last_of_run
);
    import anxb_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_rec_kind) && $stable(o_payload_byte)
        && $stable(o_unit_length), "output item changed while stalled")

    `ASSERT_IMPL(a_kind_legal, i_clk, i_rst_n, o_out_valid,
        o_rec_kind == K_PAYLOAD || o_rec_kind == K_CLOSE || o_rec_kind == K_SUMMARY,
        "illegal record kind")

    `ASSERT_IMPL(a_sum_last, i_clk, i_rst_n, o_out_valid && o_rec_kind == K_SUMMARY,
        o_last_of_run, "frame summary not last of run")

    `ASSERT_IMPL(a_nonpay_clean, i_clk, i_rst_n, o_out_valid && o_rec_kind != K_PAYLOAD,
        o_payload_byte == 8'h00 && !o_first_of_unit, "payload fields set on non-payload")

endmodule

bind annexb_nal_splitter_top anxb_checker u_anxb_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for annexb_nal_splitter_top.
// ============================================================================
// Directed rows cover the start code forms, held zero release, empty NALs
// and the frame summary. After that come random frames of start codes and
// NALs, mixed with noise and broken start codes. An in-bench parser predicts
// every payload, end-of-NAL and summary record. Both sides idle in random
// bursts except in the final stretch of the run.
// ============================================================================
module tb;
    import anxb_pkg::*;

    localparam int N_ITEMS      = 260;
    localparam int CALM_AFTER   = 220;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [4:0] T_SLICE   = 5'd1;
    localparam logic [4:0] T_SEI     = 5'd6;
    localparam logic [7:0] EMUL_PREV = 8'h03;

    typedef struct {
        logic [7:0] data;
        logic       fe;
        bit         typed;
        t_rec       rec;
    } t_stim;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = '0;
    logic        i_frame_end = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_rec_kind;
    logic [7:0]  o_payload_byte;
    logic [4:0]  o_unit_type;
    logic        o_first_of_unit;
    logic [31:0] o_unit_length;
    logic        o_is_sample_unit;
    logic        o_frame_has_idr;
    logic        o_frame_has_sps;
    logic        o_frame_has_pps;
    logic        o_frame_avcc_ok;
    logic        o_last_of_run;

    annexb_nal_splitter_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .i_frame_end      (i_frame_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rec_kind       (o_rec_kind),
        .o_payload_byte   (o_payload_byte),
        .o_unit_type      (o_unit_type),
        .o_first_of_unit  (o_first_of_unit),
        .o_unit_length    (o_unit_length),
        .o_is_sample_unit (o_is_sample_unit),
        .o_frame_has_idr  (o_frame_has_idr),
        .o_frame_has_sps  (o_frame_has_sps),
        .o_frame_has_pps  (o_frame_has_pps),
        .o_frame_avcc_ok  (o_frame_avcc_ok),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parser model state
    logic [1:0]  held_zeros;
    logic        in_nal;
    logic [31:0] nal_len;
    logic        nal_ovf;
    logic [4:0]  nal_type;
    logic [4:0]  frame_flags;

    t_rec  step_recs[$];
    t_rec  rec_exp_q[$];
    t_stim stim_q[$];
    t_rec  want;
    int    err_cnt     = 0;
    int    items_sent  = 0;
    int    stall_left  = 0;
    int    idle_cycles = 0;
    bit    calm        = 1'b0;

    function automatic t_rec make_rec(logic [1:0] kind, logic [7:0] pb, logic [4:0] ut,
                                      logic first, logic [31:0] len, logic smp,
                                      logic idr, logic sps, logic pps, logic ok,
                                      logic last);
        t_rec r;
        r.kind    = kind;
        r.pbyte   = pb;
        r.utype   = ut;
        r.first   = first;
        r.length  = len;
        r.sample  = smp;
        r.idr     = idr;
        r.sps     = sps;
        r.pps     = pps;
        r.avcc_ok = ok;
        r.last    = last;
        return r;
    endfunction

    function automatic void parser_reset();
        held_zeros  = '0;
        in_nal      = 1'b0;
        nal_len     = '0;
        nal_ovf     = 1'b0;
        nal_type    = '0;
        frame_flags = '0;
    endfunction

    function automatic void emit_payload(logic [7:0] b);
        logic first;
        if (!in_nal) return;
        first = (nal_len == '0) && !nal_ovf;
        if (first) nal_type = b[4:0];
        step_recs.insert(step_recs.size(),
                         make_rec(K_PAYLOAD, b, nal_type, first, '0, 1'b0,
                                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        if (nal_len == '1) nal_ovf = 1'b1;
        else nal_len = nal_len + 1;
    endfunction

    function automatic void release_held_zeros();
        while (held_zeros != '0) begin
            emit_payload(B_ZERO);
            held_zeros = held_zeros - 1;
        end
    endfunction

    function automatic void close_nal();
        logic smp;
        smp = !(nal_type == T_SPS || nal_type == T_PPS || nal_type == T_AUD);
        if (in_nal && (nal_len != '0 || nal_ovf)) begin
            step_recs.insert(step_recs.size(),
                             make_rec(K_CLOSE, '0, nal_type, 1'b0, nal_len, smp,
                                      1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
            if (nal_type == T_IDR) frame_flags[F_IDR] = 1'b1;
            if (nal_type == T_SPS) frame_flags[F_SPS] = 1'b1;
            if (nal_type == T_PPS) frame_flags[F_PPS] = 1'b1;
            if (smp) begin
                frame_flags[F_SMP] = 1'b1;
                if (nal_ovf) frame_flags[F_OVF] = 1'b1;
            end
        end
        nal_len  = '0;
        nal_ovf  = 1'b0;
        nal_type = '0;
    endfunction

    function automatic void nal_parse_byte(logic [7:0] b, logic fe);
        t_rec r;
        step_recs.delete();
        if (b == B_ZERO) begin
            if (held_zeros < 2'd3) held_zeros = held_zeros + 1;
            else emit_payload(B_ZERO);
        end else if (b == B_ONE && held_zeros >= 2'd2) begin
            close_nal();
            in_nal     = 1'b1;
            held_zeros = '0;
        end else begin
            release_held_zeros();
            emit_payload(b);
        end
        if (fe) begin
            release_held_zeros();
            close_nal();
            step_recs.insert(step_recs.size(),
                             make_rec(K_SUMMARY, '0, '0, 1'b0, '0, 1'b0,
                                      frame_flags[F_IDR], frame_flags[F_SPS],
                                      frame_flags[F_PPS],
                                      frame_flags[F_SMP] && !frame_flags[F_OVF], 1'b0));
            parser_reset();
        end
        if (step_recs.size() > 0) begin
            r = step_recs.pop_back();
            r.last = 1'b1;
            step_recs.insert(step_recs.size(), r);
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return B_ZERO;
            3:       return B_ONE;
            4:       return EMUL_PREV;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void add_byte(logic [7:0] b, logic fe);
        stim_q.insert(stim_q.size(), '{b, fe, 1'b0, '0});
    endfunction

    function automatic void add_typed(logic [7:0] b, logic fe, t_rec r);
        stim_q.insert(stim_q.size(), '{b, fe, 1'b1, r});
    endfunction

    function automatic void gen_frame();
        int          n_nal;
        int          len;
        logic [4:0]  ntype;
        t_stim       s;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) add_byte(rand_byte(), $urandom_range(0, 3) == 0);
            return;
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) add_byte(rand_byte(), 1'b0);
        n_nal = $urandom_range(1, 4);
        repeat (n_nal) begin
            if ($urandom_range(0, 11) == 0) begin
                add_byte(B_ZERO, 1'b0);
                add_byte(B_ONE, 1'b0);
            end else begin
                if ($urandom_range(0, 2) == 0) add_byte(B_ZERO, 1'b0);
                add_byte(B_ZERO, 1'b0);
                add_byte(B_ZERO, 1'b0);
                add_byte(B_ONE, 1'b0);
            end
            len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
            if (len > 0) begin
                case ($urandom_range(0, 6))
                    0:       ntype = T_SLICE;
                    1:       ntype = T_IDR;
                    2:       ntype = T_SPS;
                    3:       ntype = T_PPS;
                    4:       ntype = T_AUD;
                    5:       ntype = T_SEI;
                    default: ntype = 5'($urandom_range(0, 31));
                endcase
                add_byte({3'($urandom_range(0, 7)), ntype}, 1'b0);
                repeat (len - 1) begin
                    if ($urandom_range(0, 7) == 0)
                        repeat ($urandom_range(2, 6)) add_byte(B_ZERO, 1'b0);
                    else
                        add_byte(rand_byte(), 1'b0);
                end
            end
        end
        s = stim_q.pop_back();
        s.fe = 1'b1;
        stim_q.insert(stim_q.size(), s);
    endfunction

    task automatic send_stim();
        t_stim s;
        while (stim_q.size() > 0) begin
            s = stim_q.pop_front();
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_in_byte   <= s.data;
            i_frame_end <= s.fe;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            nal_parse_byte(s.data, s.fe);
            if (s.typed) rec_exp_q.insert(rec_exp_q.size(), s.rec);
            else foreach (step_recs[i]) rec_exp_q.insert(rec_exp_q.size(), step_recs[i]);
            items_sent++;
            if (items_sent >= CALM_AFTER) calm = 1'b1;
        end
    endtask

    task automatic cmp(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
            err_cnt++;
        end
    endtask

    initial begin
        parser_reset();
        // after reset: byte outside any NAL, frame end gives an empty summary
        add_typed(8'h55, 1'b1, make_rec(K_SUMMARY, '0, '0, 1'b0, '0, 1'b0,
                                        1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // four byte start code, SPS
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ONE, 1'b0);
        add_typed(8'h67, 1'b0, make_rec(K_PAYLOAD, 8'h67, T_SPS, 1'b1, '0, 1'b0,
                                        1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_typed(B_ONE, 1'b0, make_rec(K_CLOSE, '0, T_SPS, 1'b0, 32'd1, 1'b0,
                                        1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        // PPS with 01 after one zero, then a fourth zero before a start code
        add_byte(8'h68, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ONE, 1'b0);
        repeat (4) add_byte(B_ZERO, 1'b0);
        add_byte(B_ONE, 1'b0);
        // NAL opening with zeros still held at frame end
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ZERO, 1'b1);
        // AUD, IDR, then a start code on the last byte
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ONE, 1'b0);
        add_byte(8'h09, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ONE, 1'b0);
        add_byte(8'h65, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ZERO, 1'b0);
        add_byte(B_ONE, 1'b1);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_stim();
        while (items_sent < N_ITEMS) begin
            gen_frame();
            send_stim();
        end
        i_in_valid <= 1'b0;
        while (rec_exp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && rec_exp_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rec_exp_q.size() == 0) begin
                $display("%0t: unexpected record, expected none got kind %0d",
                         $time, o_rec_kind);
                err_cnt++;
            end else begin
                want = rec_exp_q.pop_front();
                cmp("rec_kind", 32'(want.kind), 32'(o_rec_kind));
                cmp("payload_byte", 32'(want.pbyte), 32'(o_payload_byte));
                cmp("unit_type", 32'(want.utype), 32'(o_unit_type));
                cmp("first_of_unit", 32'(want.first), 32'(o_first_of_unit));
                cmp("unit_length", want.length, o_unit_length);
                cmp("is_sample_unit", 32'(want.sample), 32'(o_is_sample_unit));
                cmp("frame_has_idr", 32'(want.idr), 32'(o_frame_has_idr));
                cmp("frame_has_sps", 32'(want.sps), 32'(o_frame_has_sps));
                cmp("frame_has_pps", 32'(want.pps), 32'(o_frame_has_pps));
                cmp("frame_avcc_ok", 32'(want.avcc_ok), 32'(o_frame_avcc_ok));
                cmp("last_of_run", 32'(want.last), 32'(o_last_of_run));
            end
        end
    end

    // watchdog: cycles without any accepted item on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
